[rtl/sle_pkg.sv]
// Shared constants, result kinds and sequencer states for the serial line editor.
// No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

  // Line store depth and derived widths
  localparam int LINE_DEPTH = 64;
  localparam int AW         = $clog2(LINE_DEPTH);      // store address
  localparam int CW         = $clog2(LINE_DEPTH + 1);  // count 0..LINE_DEPTH
  localparam int LIM_W      = 7;                       // read_limit field

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // Input ops
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Special characters
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_BS     = 8'h7F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHAR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_TERM,
    ST_EMIT_ONE,
    ST_RD_START,
    ST_RD_ISSUE,
    ST_RD_EMIT
  } state_t;

endpackage

[rtl/serial_line_editor_core.sv]
// Serial line editor: edit line assembly, line commit and line readout.
// A character beat passes ST_CHAR and ST_EMIT_ONE; a commit adds a ST_COPY_RD / ST_COPY_WR
// pair per byte and ST_TERM; a read passes ST_RD_START, then ST_RD_ISSUE and ST_RD_EMIT per byte.
// One beat in flight: no new beat is taken until the sequencer is back in ST_IDLE, and
// the emit states wait while out_ready holds a result back.
// Reset (rst_n, synchronous): counts to zero, output empty; stores uncleared, written first.
`timescale 1ns / 1ps

module serial_line_editor_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_char,
  input  logic [6:0] in_read_limit,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_last
);

  localparam int DEPTH = sle_pkg::LINE_DEPTH;
  localparam int AW    = sle_pkg::AW;
  localparam int CW    = sle_pkg::CW;
  localparam int LW    = sle_pkg::LIM_W;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  sle_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] edit_cnt_r, edit_cnt_nxt;   // characters held in edit line
  logic [CW-1:0] line_len_r, line_len_nxt;   // committed length incl. terminator
  logic [CW-1:0] idx_r,      idx_nxt;        // walk index for copy / read
  logic [CW-1:0] n_r,        n_nxt;          // walk length

  // Latched input beat
  logic [7:0]    ch_r;
  logic [LW-1:0] lim_r;

  // Pending single result (echo or "no line")
  logic [1:0] pend_kind_r, pend_kind_nxt;
  logic [7:0] pend_data_r, pend_data_nxt;

  // Output register
  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_load;
  logic [1:0] load_kind;
  logic [7:0] load_data;
  logic       load_last;
  logic       slot_free;

  // ---------------------------------------------------------------------------
  // Stores: one write port, one registered read port each
  // ---------------------------------------------------------------------------
  logic [7:0]    edit_mem [DEPTH];
  logic [7:0]    line_mem [DEPTH];

  logic          edit_we, line_we;
  logic [AW-1:0] edit_waddr, line_waddr;
  logic [7:0]    edit_wdata, line_wdata;
  logic          edit_re, line_re;
  logic [AW-1:0] edit_raddr, line_raddr;
  logic [7:0]    edit_rdata_r, line_rdata_r;

  always_ff @(posedge clk) begin
    if (edit_we) begin
      edit_mem[edit_waddr] <= edit_wdata;
    end
    if (edit_re) begin
      edit_rdata_r <= edit_mem[edit_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (line_re) begin
      line_rdata_r <= line_mem[line_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  // Input is taken whenever the sequencer is idle; a result may still sit in
  // the output register, the emit states wait for the slot instead.
  assign in_ready  = (state_r == sle_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sle_pkg::ST_IDLE;
      edit_cnt_r <= '0;
      line_len_r <= '0;
    end else begin
      state_r    <= state_nxt;
      edit_cnt_r <= edit_cnt_nxt;
      line_len_r <= line_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_data_r <= pend_data_nxt;
    if (in_valid && in_ready) begin
      ch_r  <= in_rx_char;
      lim_r <= in_read_limit;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    edit_cnt_nxt  = edit_cnt_r;
    line_len_nxt  = line_len_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    pend_kind_nxt = pend_kind_r;
    pend_data_nxt = pend_data_r;

    edit_we    = 1'b0;
    edit_waddr = edit_cnt_r[AW-1:0];
    edit_wdata = ch_r;
    edit_re    = 1'b0;
    edit_raddr = idx_r[AW-1:0];
    line_we    = 1'b0;
    line_waddr = idx_r[AW-1:0];
    line_wdata = edit_rdata_r;
    line_re    = 1'b0;
    line_raddr = idx_r[AW-1:0];

    out_load  = 1'b0;
    load_kind = pend_kind_r;
    load_data = pend_data_r;
    load_last = 1'b1;

    case (state_r)
      sle_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == sle_pkg::OP_READ) ? sle_pkg::ST_RD_START
                                                   : sle_pkg::ST_CHAR;
        end
      end

      // Classify the character and update the edit line
      sle_pkg::ST_CHAR: begin
        pend_kind_nxt = sle_pkg::KIND_ECHO;
        pend_data_nxt = ch_r;
        state_nxt     = sle_pkg::ST_EMIT_ONE;
        if (ch_r inside {sle_pkg::CH_CTRL_C, sle_pkg::CH_ESC}) begin
          edit_cnt_nxt  = '0;
          pend_data_nxt = sle_pkg::CH_CR;
        end else if (ch_r == sle_pkg::CH_BS) begin
          if (edit_cnt_r != '0) begin
            edit_cnt_nxt = edit_cnt_r - 1'b1;
          end
        end else if (ch_r inside {sle_pkg::CH_CR, sle_pkg::CH_LF}) begin
          if (edit_cnt_r != '0) begin
            n_nxt     = edit_cnt_r;
            idx_nxt   = '0;
            state_nxt = sle_pkg::ST_COPY_RD;
          end
        end else if (edit_cnt_r < CW'(DEPTH)) begin
          edit_we      = 1'b1;
          edit_cnt_nxt = edit_cnt_r + 1'b1;
        end
      end

      // Commit: copy edit line into line store, one byte per ST_COPY_RD / ST_COPY_WR pair
      sle_pkg::ST_COPY_RD: begin
        edit_re   = 1'b1;
        state_nxt = sle_pkg::ST_COPY_WR;
      end

      sle_pkg::ST_COPY_WR: begin
        line_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == n_r) begin
          state_nxt = sle_pkg::ST_TERM;
        end else begin
          state_nxt = sle_pkg::ST_COPY_RD;
        end
      end

      // Zero terminator if the line is not full
      sle_pkg::ST_TERM: begin
        edit_cnt_nxt = '0;
        line_waddr   = n_r[AW-1:0];
        line_wdata   = sle_pkg::CH_NUL;
        if (n_r < CW'(DEPTH)) begin
          line_we      = 1'b1;
          line_len_nxt = n_r + 1'b1;
        end else begin
          line_len_nxt = n_r;
        end
        state_nxt = sle_pkg::ST_EMIT_ONE;
      end

      // Single-beat result: echo or empty read
      sle_pkg::ST_EMIT_ONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = sle_pkg::ST_IDLE;
        end
      end

      // Read: clamp to read_limit, then stream the line
      sle_pkg::ST_RD_START: begin
        line_len_nxt = '0;
        idx_nxt      = '0;
        if (lim_r < LW'(line_len_r)) begin
          n_nxt = CW'(lim_r);
        end else begin
          n_nxt = line_len_r;
        end
        if (lim_r == '0 || line_len_r == '0) begin
          pend_kind_nxt = sle_pkg::KIND_NONE;
          pend_data_nxt = '0;
          state_nxt     = sle_pkg::ST_EMIT_ONE;
        end else begin
          state_nxt = sle_pkg::ST_RD_ISSUE;
        end
      end

      sle_pkg::ST_RD_ISSUE: begin
        line_re   = 1'b1;
        state_nxt = sle_pkg::ST_RD_EMIT;
      end

      sle_pkg::ST_RD_EMIT: begin
        load_kind = sle_pkg::KIND_LINE;
        load_data = line_rdata_r;
        load_last = (idx_r + 1'b1 == n_r);
        if (slot_free) begin
          out_load  = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = load_last ? sle_pkg::ST_IDLE : sle_pkg::ST_RD_ISSUE;
        end
      end

      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= load_kind;
      out_data_r <= load_data;
      out_last_r <= load_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_edit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    edit_cnt_r <= CW'(DEPTH))
    else $error("edit count beyond line depth");

  a_line_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= CW'(DEPTH))
    else $error("line length beyond line depth");

  a_read_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == sle_pkg::OP_READ) |=> ##1 (line_len_r == '0))
    else $error("read did not clear committed line");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("result loaded over an untaken beat");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for serial_line_editor_core: editing keys, line commit
// and line readout, checked against a behavioral line-editor model kept in the bench.
// Depends on sle_pkg (rtl/sle_pkg.sv) and the serial_line_editor_core RTL.
`timescale 1ns / 1ps

module tb_top;

  // One result beat as seen on the out_ channel
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } line_result_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic       in_op         = sle_pkg::OP_CHAR;
  logic [7:0] in_rx_char    = 8'h00;
  logic [6:0] in_read_limit = 7'd0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic       out_last;

  serial_line_editor_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_rx_char    (in_rx_char),
    .in_read_limit (in_read_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_last      (out_last)
  );

  // Bench copy of the editor state. Only entries below edit_len / held_len are
  // ever read, and those were always written first.
  logic [7:0] edit_buf [sle_pkg::LINE_DEPTH];
  int         edit_len;
  logic [7:0] held_buf [sle_pkg::LINE_DEPTH];
  int         held_len;

  // Results the block still owes, oldest first
  line_result_t owed_results[$];

  // Idle knobs, in percent per cycle
  int sender_idle_pct;
  int recv_stall_pct;

  // Bookkeeping for the closing summary
  int n_errors;
  int n_beats;
  int n_results;
  int n_commits;
  int n_full_commits;
  int n_data_reads;
  int n_empty_reads;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far past any correct run.
  initial begin
    #10_000_000;
    $display("Timeout: %0d results still owed", owed_results.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line-editor prediction. Applies one accepted input beat to the bench state
  // and queues every result beat that it must cause.
  // ---------------------------------------------------------------------------
  task automatic edit_and_predict(input logic op, input logic [7:0] ch,
                                  input logic [6:0] lim);
    line_result_t r;
    logic [7:0]   echo;
    int           n;
    if (op == sle_pkg::OP_CHAR) begin
      echo = ch;
      if (ch == sle_pkg::CH_CTRL_C || ch == sle_pkg::CH_ESC) begin
        // clear key: drop the edit line, echo CR instead of the key
        edit_len = 0;
        echo     = sle_pkg::CH_CR;
      end else if (ch == sle_pkg::CH_BS) begin
        if (edit_len > 0) edit_len--;
      end else if (ch == sle_pkg::CH_CR || ch == sle_pkg::CH_LF) begin
        // commit only a non-empty line; add a NUL while there is room
        if (edit_len > 0) begin
          for (int i = 0; i < edit_len; i++) held_buf[i] = edit_buf[i];
          held_len = edit_len;
          if (edit_len < sle_pkg::LINE_DEPTH) begin
            held_buf[edit_len] = sle_pkg::CH_NUL;
            held_len++;
          end else begin
            n_full_commits++;
          end
          n_commits++;
          edit_len = 0;
        end
      end else if (edit_len < sle_pkg::LINE_DEPTH) begin
        // ordinary byte; dropped (still echoed) once the line is full
        edit_buf[edit_len] = ch;
        edit_len++;
      end
      r.kind = sle_pkg::KIND_ECHO;
      r.data = echo;
      r.last = 1'b1;
      owed_results.push_back(r);
    end else begin
      // read: up to lim held bytes, then the held line is gone either way
      n = held_len;
      if (int'(lim) < n) n = int'(lim);
      held_len = 0;
      if (n == 0) begin
        r.kind = sle_pkg::KIND_NONE;
        r.data = 8'h00;
        r.last = 1'b1;
        owed_results.push_back(r);
        n_empty_reads++;
      end else begin
        for (int i = 0; i < n; i++) begin
          r.kind = sle_pkg::KIND_LINE;
          r.data = held_buf[i];
          r.last = (i == n - 1);
          owed_results.push_back(r);
        end
        n_data_reads++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 30)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. Signals are read in the active region of the edge, so they
  // hold the values the block itself saw at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result beat, kind", out_kind, 0);
      end else begin
        want = owed_results.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_data !== want.data) report_mismatch("data", out_data, want.data);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Receiver back-pressure: one fresh ready decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Beat driver. Entered at a rising edge. Valid is only lowered when an idle
  // gap is taken, so back-to-back beats never see valid dropped and re-raised
  // in the same time step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic op, input logic [7:0] ch, input logic [6:0] lim);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_rx_char    <= ch;
    in_read_limit <= lim;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge
    edit_and_predict(op, ch, lim);
    n_beats++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_beat(sle_pkg::OP_CHAR, ch, 7'($urandom_range(127)));
  endtask

  task automatic send_read(input logic [6:0] lim);
    send_beat(sle_pkg::OP_READ, 8'($urandom_range(255)), lim);
  endtask

  // Hold the sender off until every owed result has come out
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == sle_pkg::CH_CTRL_C || c == sle_pkg::CH_ESC || c == sle_pkg::CH_BS ||
           c == sle_pkg::CH_CR || c == sle_pkg::CH_LF)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short directed walk through the editing keys and the read corner cases
  task automatic test_directed_edits();
    send_read(7'd5);                // nothing held yet -> single "no line" beat
    send_char(sle_pkg::CH_BS);      // backspace on an empty line
    send_char(sle_pkg::CH_CR);      // CR on an empty line commits nothing
    send_char(sle_pkg::CH_LF);
    send_char(8'h00);               // byte extremes go into the line
    send_char(8'hFF);
    send_char(sle_pkg::CH_CTRL_C);  // clear, echoes CR
    send_char(8'h41);
    send_char(8'h42);
    send_char(sle_pkg::CH_BS);      // drops the 'B'
    send_char(sle_pkg::CH_ESC);     // clear again
    send_char(8'h68);
    send_char(8'h69);
    send_char(sle_pkg::CH_CR);      // commit "hi" plus NUL
    send_read(7'd127);              // limit above the length: whole line
    send_read(7'd3);                // already consumed
    send_char(8'h78);
    send_char(8'h79);
    send_char(8'h7A);
    send_char(sle_pkg::CH_LF);      // commit via LF
    send_read(7'd0);                // zero limit throws the held line away
    send_read(7'd64);
    send_char(8'h71);
    send_char(sle_pkg::CH_CR);
    send_read(7'd1);                // partial read, last on the only byte
  endtask

  // Fill the edit line past its depth, commit it with no room for the NUL
  task automatic test_full_line();
    send_char(sle_pkg::CH_ESC);
    for (int i = 0; i < sle_pkg::LINE_DEPTH + 2; i++) send_char(pick_plain_char());
    send_char(sle_pkg::CH_CR);
    send_read(7'(sle_pkg::LINE_DEPTH));
    wait_until_drained();
  endtask

  // Mostly well-formed lines with random content, the rest raw noise beats
  task automatic test_random_traffic(input int n_target, input int idle_pct,
                                     input int stall_pct);
    int start_beats;
    int len;
    logic [6:0] lim;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start_beats     = n_beats;
    while (n_beats - start_beats < n_target) begin
      if ($urandom_range(99) < 75) begin
        len = $urandom_range(12);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(99) < 8) send_char(sle_pkg::CH_BS);
          else send_char(pick_plain_char());
        end
        case ($urandom_range(9))
          0:       send_char($urandom_range(1) ? sle_pkg::CH_CTRL_C : sle_pkg::CH_ESC);
          1, 2, 3: send_char(sle_pkg::CH_LF);
          default: send_char(sle_pkg::CH_CR);
        endcase
        if ($urandom_range(99) < 70) begin
          lim = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
          send_read(lim);
        end
        // now and then let the block run completely dry
        if ($urandom_range(99) < 10) wait_until_drained();
      end else begin
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 7'($urandom_range(127)));
      end
    end
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    n_errors        = 0;
    n_beats         = 0;
    n_results       = 0;
    n_commits       = 0;
    n_full_commits  = 0;
    n_data_reads    = 0;
    n_empty_reads   = 0;
    edit_len        = 0;
    held_len        = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edits();
    wait_until_drained();
    test_full_line();

    // idle phases: none, sender gaps, receiver stalls, both
    test_random_traffic(32, 0, 0);
    test_random_traffic(32, 60, 0);
    test_random_traffic(32, 0, 60);
    test_random_traffic(32, 36, 36);

    // all beats are in; let stragglers out, then a short quiet tail
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d input beats, checked %0d result beats.", n_beats, n_results);
    $display("Lines committed: %0d (%0d full), reads with data: %0d, empty reads: %0d.",
             n_commits, n_full_commits, n_data_reads, n_empty_reads);
    if (n_errors == 0 && owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors, owed_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
